>>> src/dpcc_pkg.sv
// shared constants and types for the disc pixel coverage counter
package dpcc_pkg;

    // half extent of the scanned grid, pixel indices run -MAX_EXTENT..MAX_EXTENT
    localparam int MAX_EXTENT = 64;

    localparam int IN_W   = 16;
    localparam int IDX_W  = $clog2(MAX_EXTENT + 1);
    // doubled corner offset (2k-1)*width and its square
    localparam int OFS_W  = IN_W + $clog2(2 * MAX_EXTENT);
    localparam int SQ_W   = 2 * OFS_W;
    localparam int PROD_W = 2 * IN_W;
    localparam int LIM_W  = PROD_W + 2;
    localparam int CNT_W  = $clog2((2 * MAX_EXTENT + 1) * (2 * MAX_EXTENT + 1) + 1);
    localparam int OUT_CNT_W = 15;
    localparam int COUNT_MAX = 32767;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR_R,
        S_SQR_W,
        S_ROW,
        S_COL,
        S_FIN
    } t_state;

endpackage

>>> src/disc_pixel_coverage_count_top.sv
// disc pixel coverage counter: counts grid pixels with a corner inside a disc
//
// Each beat on the slave side carries a disc radius and a pixel width (both
// unsigned Q4.12); one beat on the master side returns the number of pixels of
// the centred grid that have at least one corner within the radius, plus a flag
// that is set when a qualifying pixel lies on the outermost ring of the grid.
// Each item passes through a radius squaring step and a width squaring step,
// then for each qualifying row a row step plus a column step per tested pixel
// of that quadrant row (qualifying pixels plus the first failing one, at most
// MAX_EXTENT+1), one more row step when a row fails, and a finish step that
// posts the result and waits while the previous result is still unread. The
// column scan steps a single add and compare unit over one pixel each cycle,
// with squared offsets built up by running sums.
// The slave side is not ready while an item is in work; a finished result
// waits in an output register, so the next item may be taken meanwhile.
module disc_pixel_coverage_count_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // radius[15:0], pixel_size[31:16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // pixel_count[14:0], zero[15]
    output logic        o_m_axis_tuser    // truncated[0]
);
    import dpcc_pkg::*;

    t_state r_state, n_state;

    logic [IN_W-1:0]      r_rad, n_rad;
    logic [IN_W-1:0]      r_wid, n_wid;
    logic [LIM_W-1:0]     r_limit, n_limit;
    logic [PROD_W-1:0]    r_w2, n_w2;
    logic [SQ_W-1:0]      r_sqx, n_sqx;
    logic [SQ_W-1:0]      r_dlx, n_dlx;
    logic [LIM_W-1:0]     r_rem, n_rem;
    logic [SQ_W-1:0]      r_sqy, n_sqy;
    logic [SQ_W-1:0]      r_dly, n_dly;
    logic [IDX_W-1:0]     r_i, n_i;
    logic [IDX_W-1:0]     r_j, n_j;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_edge, n_edge;
    logic                 r_ovalid, n_ovalid;
    logic [OUT_CNT_W-1:0] r_ocount, n_ocount;
    logic                 r_oedge, n_oedge;

    logic                 in_accept;
    logic                 out_load;
    logic [IN_W-1:0]      mul_op;
    logic [PROD_W-1:0]    prod;
    logic [SQ_W-1:0]      w8;
    logic                 row_fail;
    logic                 col_fail;
    logic                 last_row;
    logic                 last_col;
    logic                 row_end;
    logic [1:0]           wt_shift;
    logic [OUT_CNT_W-1:0] sat_count;

    // shared squarer: radius first, then width
    assign mul_op   = (r_state == S_SQR_R) ? r_rad : r_wid;
    assign prod     = PROD_W'(mul_op) * PROD_W'(mul_op);
    assign w8       = SQ_W'({r_w2, 3'b000});

    assign row_fail = r_sqx > SQ_W'(r_limit);
    assign col_fail = r_sqy > SQ_W'(r_rem);
    assign last_row = r_i == IDX_W'(MAX_EXTENT);
    assign last_col = r_j == IDX_W'(MAX_EXTENT);
    assign row_end  = col_fail || last_col;
    // weight 1, 2 or 4 by quadrant symmetry
    assign wt_shift = {1'b0, (r_i != '0)} + {1'b0, (r_j != '0)};

    assign sat_count = (32'(r_count) > 32'(COUNT_MAX)) ? OUT_CNT_W'(COUNT_MAX)
                                                       : OUT_CNT_W'(r_count);

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        out_load        = (r_state == S_FIN) && (!r_ovalid || i_m_axis_tready);
    end

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_SQR_R;
            end
            S_SQR_R: n_state = S_SQR_W;
            S_SQR_W: n_state = S_ROW;
            S_ROW: begin
                n_state = row_fail ? S_FIN : S_COL;
            end
            S_COL: begin
                if (row_end) n_state = last_row ? S_FIN : S_ROW;
            end
            S_FIN: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_rad    = r_rad;
        n_wid    = r_wid;
        n_limit  = r_limit;
        n_w2     = r_w2;
        n_sqx    = r_sqx;
        n_dlx    = r_dlx;
        n_rem    = r_rem;
        n_sqy    = r_sqy;
        n_dly    = r_dly;
        n_i      = r_i;
        n_j      = r_j;
        n_count  = r_count;
        n_edge   = r_edge;
        n_ocount = r_ocount;
        n_oedge  = r_oedge;
        n_ovalid = r_ovalid;

        if (r_ovalid && i_m_axis_tready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_rad = i_s_axis_tdata[IN_W-1:0];
                    n_wid = i_s_axis_tdata[2*IN_W-1:IN_W];
                end
            end
            S_SQR_R: begin
                n_limit = {prod, 2'b00};
            end
            S_SQR_W: begin
                // offsets squared: w^2, w^2, then running sum with step 8k*w^2
                n_w2    = prod;
                n_sqx   = SQ_W'(prod);
                n_dlx   = '0;
                n_i     = '0;
                n_count = '0;
                n_edge  = 1'b0;
            end
            S_ROW: begin
                n_rem = r_limit - r_sqx[LIM_W-1:0];
                n_sqy = SQ_W'(r_w2);
                n_dly = '0;
                n_j   = '0;
            end
            S_COL: begin
                if (!col_fail) begin
                    n_count = r_count + (CNT_W'(1) << wt_shift);
                    if (last_row || last_col) n_edge = 1'b1;
                end
                if (row_end) begin
                    if (!last_row) begin
                        n_i   = r_i + IDX_W'(1);
                        n_sqx = r_sqx + r_dlx;
                        n_dlx = r_dlx + w8;
                    end
                end else begin
                    n_j   = r_j + IDX_W'(1);
                    n_sqy = r_sqy + r_dly;
                    n_dly = r_dly + w8;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_ocount = sat_count;
                    n_oedge  = r_edge;
                    n_ovalid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad    <= n_rad;
        r_wid    <= n_wid;
        r_limit  <= n_limit;
        r_w2     <= n_w2;
        r_sqx    <= n_sqx;
        r_dlx    <= n_dlx;
        r_rem    <= n_rem;
        r_sqy    <= n_sqy;
        r_dly    <= n_dly;
        r_i      <= n_i;
        r_j      <= n_j;
        r_count  <= n_count;
        r_edge   <= n_edge;
        r_ocount <= n_ocount;
        r_oedge  <= n_oedge;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_ocount};
    assign o_m_axis_tuser  = r_oedge;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_SQR_R)
        else $error("accepted beat did not start the squaring step");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == S_FIN)
        else $error("result posted outside the finish step");

    a_scan_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> (r_i <= IDX_W'(MAX_EXTENT) && r_j <= IDX_W'(MAX_EXTENT)))
        else $error("scan index beyond grid extent");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL || r_state == S_FIN) |->
            32'(r_count) <= 32'((2 * MAX_EXTENT + 1) * (2 * MAX_EXTENT + 1)))
        else $error("pixel count exceeds grid size");
`endif

endmodule

>>> bench/disc_pixel_coverage_count_top_tb.sv
// testbench for the disc pixel coverage counter: directed table, random beats, predictor check
module disc_pixel_coverage_count_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpcc_pkg::*;

    typedef struct packed {
        logic [14:0] pixel_count;
        logic        truncated;
    } coverage_result_t;

    typedef struct packed {
        logic [15:0] radius;
        logic [15:0] width;
        logic        has_want;
        logic [14:0] pixel_count;
        logic        truncated;
    } disc_row_t;

    localparam int N_ROWS     = 19;
    localparam int N_RANDOM   = 111;
    localparam int HOLD_CYCLES = 12000;
    localparam int TAIL_CYCLES = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    // both sides stop random idling while this is set
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    coverage_result_t pending_counts [$];

    // extremes carry a typed expectation, the rest go through the predictor
    disc_row_t disc_rows [0:N_ROWS-1] = '{
        '{16'hFFFF, 16'h0001, 1'b1, 15'd16641, 1'b1},
        '{16'h0000, 16'h0001, 1'b1, 15'd0,     1'b0},
        '{16'h0000, 16'h0000, 1'b1, 15'd16641, 1'b1},
        '{16'hFFFF, 16'h0000, 1'b1, 15'd16641, 1'b1},
        '{16'h0001, 16'hFFFF, 1'b1, 15'd0,     1'b0},
        '{16'hFFFF, 16'hFFFF, 1'b0, 15'd0,     1'b0},
        '{16'h0800, 16'h1000, 1'b0, 15'd0,     1'b0},
        '{16'h07FF, 16'h1000, 1'b0, 15'd0,     1'b0},
        '{16'd16256, 16'd256, 1'b0, 15'd0,     1'b0},
        '{16'd16257, 16'd256, 1'b0, 15'd0,     1'b0},
        '{16'hAAAA, 16'h5555, 1'b0, 15'd0,     1'b0},
        '{16'h5555, 16'hAAAA, 1'b0, 15'd0,     1'b0},
        '{16'h8000, 16'h0001, 1'b0, 15'd0,     1'b0},
        '{16'h3000, 16'h0100, 1'b0, 15'd0,     1'b0},
        '{16'h1000, 16'h1000, 1'b0, 15'd0,     1'b0},
        '{16'h0001, 16'h0001, 1'b0, 15'd0,     1'b0},
        '{16'hFFFF, 16'h0402, 1'b0, 15'd0,     1'b0},
        '{16'h7FFF, 16'h8000, 1'b0, 15'd0,     1'b0},
        '{16'h0002, 16'h0001, 1'b0, 15'd0,     1'b0}
    };

    disc_pixel_coverage_count_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // twice the nearest corner offset along one axis
    function automatic longint unsigned corner_offset(input int k, input logic [15:0] w);
        if (k == 0)
            return longint'(w);
        return longint'(2 * k - 1) * longint'(w);
    endfunction

    function automatic coverage_result_t predict_coverage(input logic [15:0] rad,
                                                          input logic [15:0] w);
        longint unsigned  limit;
        longint unsigned  dx2;
        longint unsigned  dy;
        longint unsigned  total;
        bit               on_ring;
        coverage_result_t res;
        limit = 4 * longint'(rad) * longint'(rad);
        total = 0;
        on_ring = 1'b0;
        for (int i = 0; i <= MAX_EXTENT; i++) begin
            dx2 = corner_offset(i, w) * corner_offset(i, w);
            if (dx2 > limit)
                break;
            for (int j = 0; j <= MAX_EXTENT; j++) begin
                dy = corner_offset(j, w);
                if (dx2 + dy * dy > limit)
                    break;
                total += ((i == 0) ? 1 : 2) * ((j == 0) ? 1 : 2);
                if (i == MAX_EXTENT || j == MAX_EXTENT)
                    on_ring = 1'b1;
            end
        end
        if (total > COUNT_MAX)
            total = COUNT_MAX;
        res.pixel_count = total[14:0];
        res.truncated = on_ring;
        return res;
    endfunction

    // offer one beat, queue its expected count once it is taken
    task automatic send_disc(input logic [15:0] rad, input logic [15:0] w,
                             input coverage_result_t want);
        while (!calm && $urandom_range(0, 99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {w, rad};
        do @(posedge clk); while (!s_tready);
        pending_counts.push_back(want);
    endtask

    task automatic wait_drained();
        while (pending_counts.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        logic [15:0]      rad;
        logic [15:0]      w;
        int unsigned      prod;
        coverage_result_t want;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_ROWS; k++) begin
            if (disc_rows[k].has_want)
                want = '{disc_rows[k].pixel_count, disc_rows[k].truncated};
            else
                want = predict_coverage(disc_rows[k].radius, disc_rows[k].width);
            send_disc(disc_rows[k].radius, disc_rows[k].width, want);
        end

        // sender pauses until everything is back
        s_tvalid <= 1'b0;
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 60 && n < 90);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    rad = 16'($urandom);
                    w = 16'($urandom);
                end
                3, 4, 5, 6: begin
                    // radius a random multiple of the width in steps of 1/16, up to past the grid edge
                    w = 16'($urandom_range(1, 4095));
                    prod = (int'(w) * $urandom_range(0, 1100)) / 16;
                    rad = (prod > 65535) ? 16'hFFFF : prod[15:0];
                end
                default: begin
                    // near the outermost ring
                    w = 16'($urandom_range(1, 1023));
                    prod = int'(w) * 63 + $urandom_range(0, 2 * int'(w));
                    rad = (prod > 65535) ? 16'hFFFF : prod[15:0];
                end
            endcase
            send_disc(rad, w, predict_coverage(rad, w));
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        while (pending_counts.size() != 0) begin
            want = pending_counts.pop_front();
            if (mismatches < 10)
                $display("missing result: expected count %0d truncated %0d",
                         want.pixel_count, want.truncated);
            mismatches++;
        end
        if (mismatches == 0)
            $display("disc_pixel_coverage_count_top_tb: clean");
        else
            $display("disc_pixel_coverage_count_top_tb: errors");
        $finish;
    end

    // receiver: random idling, one long hold-off once the run is under way
    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 40) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 38);
        end
    end

    always @(posedge clk) begin : check_counts
        coverage_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (pending_counts.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected beat: count %0d truncated %0d",
                             m_tdata[14:0], m_tuser);
                mismatches++;
            end else begin
                want = pending_counts.pop_front();
                // bit 15 of the data is padding and must read zero
                if (m_tdata !== {1'b0, want.pixel_count} ||
                    m_tuser !== want.truncated) begin
                    if (mismatches < 10)
                        $display({"mismatch: expected count %0d truncated %0d, ",
                                  "got %0d (tdata %h) truncated %b"},
                                 want.pixel_count, want.truncated, m_tdata[14:0], m_tdata,
                                 m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #(40_000_000);
        $display("disc_pixel_coverage_count_top_tb: errors");
        $finish;
    end

endmodule
